/* hw/rtl/ctdf_pkg.sv */
package ctdf_pkg;

    // Table geometry
    localparam int ETA_ROWS       = 32;
    localparam int DEPTH_COLUMNS  = 8;
    localparam int TABLE_DEPTH    = ETA_ROWS * DEPTH_COLUMNS;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int THR_W          = 7;

    // Eta limits
    localparam int TIMING_ETA_MAX = 29;
    localparam int BARREL_ETA_MAX = 16;
    localparam int LOW_ETA_MAX    = 20;

    // Register reset values
    localparam logic [15:0] MIN_E_LOW_RST  = 16'd64;
    localparam logic [15:0] MIN_E_HIGH_RST = 16'd128;
    localparam logic [15:0] DEEP_LOW_RST   = 16'd80;
    localparam logic [15:0] EARLY_LOW_RST  = 16'd16;
    localparam logic [15:0] DEEP_HIGH_RST  = 16'd160;
    localparam logic [15:0] EARLY_HIGH_RST = 16'd32;

    // Input item kinds
    localparam logic MODE_CELL  = 1'b0;
    localparam logic MODE_TABLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_E_LOW  = 3'd0,
        CFG_MIN_E_HIGH = 3'd1,
        CFG_DEEP_LOW   = 3'd2,
        CFG_EARLY_LOW  = 3'd3,
        CFG_DEEP_HIGH  = 3'd4,
        CFG_EARLY_HIGH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] min_e_low;
        logic [15:0] min_e_high;
        logic [15:0] deep_low;
        logic [15:0] early_low;
        logic [15:0] deep_high;
        logic [15:0] early_high;
    } t_cfg;

    // Per-cell decode carried from the table read stage to the classify stage
    typedef struct packed {
        logic timing_ok;    // cell may contribute to timing flags
        logic low_eta;      // |eta| in the low band
        logic early_depth;  // depth 2 or less
        logic depth_nz;     // depth is not zero
        logic last;         // final cell of the tower
    } t_cell_info;

    function automatic logic [1:0] sat_inc(input logic [1:0] c);
        logic [1:0] r;
        r = (c == 2'd3) ? 2'd3 : c + 2'd1;
        return r;
    endfunction

endpackage

/* hw/rtl/ctdf_ram.sv */
module ctdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ctdf_decode.sv */
module ctdf_decode (
    input  logic signed [5:0]             i_tower_eta,
    input  logic [2:0]                    i_depth_index,
    input  logic                          i_last_cell,
    output logic [ctdf_pkg::ADDR_W-1:0]   o_addr,
    output logic                          o_slot_ok,
    output ctdf_pkg::t_cell_info          o_info
);
    import ctdf_pkg::*;

    logic [5:0] mag;
    logic       slot_ok;
    logic [5:0] row;
    logic [2:0] col;

    // |eta|; -32 maps to 32, which fits in six unsigned bits
    assign mag = i_tower_eta[5] ? (~i_tower_eta + 6'd1) : i_tower_eta;

    assign slot_ok = (mag != 6'd0) && (32'(mag) <= ETA_ROWS) &&
                     (i_depth_index != 3'd0) && (32'(i_depth_index) <= DEPTH_COLUMNS);

    assign row = mag - 6'd1;
    assign col = i_depth_index - 3'd1;

    // Table entry: row-major, one row per |eta|
    assign o_addr = slot_ok ? ADDR_W'(32'(row) * DEPTH_COLUMNS + 32'(col)) : '0;
    assign o_slot_ok = slot_ok;

    always_comb begin
        o_info.timing_ok   = slot_ok && (32'(mag) <= TIMING_ETA_MAX) &&
                             ((32'(mag) <= BARREL_ETA_MAX) || (i_depth_index >= 3'd2));
        o_info.low_eta     = (32'(mag) <= LOW_ETA_MAX);
        o_info.early_depth = (i_depth_index <= 3'd2);
        o_info.depth_nz    = (i_depth_index != 3'd0);
        o_info.last        = i_last_cell;
    end

endmodule

/* hw/rtl/ctdf_accum.sv */
module ctdf_accum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  ctdf_pkg::t_cell_info      i_info,
    input  logic [5:0]                i_cell_time,
    input  logic [15:0]               i_cell_energy,
    input  logic [ctdf_pkg::THR_W-1:0] i_thr,
    input  ctdf_pkg::t_cfg            i_cfg,
    output logic [5:0]                o_flags
);
    import ctdf_pkg::*;

    logic [1:0]  r_dly, n_dly;
    logic [1:0]  r_vdly, n_vdly;
    logic        r_prompt, n_prompt;
    logic        r_early, n_early;
    logic        r_deep, n_deep;

    logic [6:0]  t;
    logic [7:0]  th_lim;
    logic [15:0] emin;
    logic [15:0] early_lim;
    logic [15:0] deep_lim;
    logic        hit;
    logic        is_dly;
    logic        is_vdly;
    logic        is_prompt;
    logic        early_hit;
    logic        deep_hit;

    // Cell time in half-ns against threshold and threshold + 2
    assign t      = {i_cell_time, 1'b0};
    assign th_lim = {1'b0, i_thr} + 8'd2;

    assign emin      = i_info.low_eta ? i_cfg.min_e_low : i_cfg.min_e_high;
    assign early_lim = i_info.low_eta ? i_cfg.early_low : i_cfg.early_high;
    assign deep_lim  = i_info.low_eta ? i_cfg.deep_low  : i_cfg.deep_high;

    assign hit       = i_info.timing_ok && (i_cell_energy >= emin);
    assign is_dly    = hit && (t > i_thr) && ({1'b0, t} <= th_lim);
    assign is_vdly   = hit && ({1'b0, t} > th_lim);
    assign is_prompt = hit && (t <= i_thr) && (t != 7'd0);

    assign early_hit = i_info.depth_nz && i_info.early_depth && (i_cell_energy > early_lim);
    assign deep_hit  = i_info.depth_nz && !i_info.early_depth && (i_cell_energy > deep_lim);

    // Tower state including this cell
    always_comb begin
        n_dly    = is_dly  ? sat_inc(r_dly)  : r_dly;
        n_vdly   = is_vdly ? sat_inc(r_vdly) : r_vdly;
        n_prompt = r_prompt || is_prompt;
        n_early  = r_early || early_hit;
        n_deep   = r_deep || deep_hit;
    end

    assign o_flags = {n_deep && !n_early, n_vdly, n_dly, n_prompt};

    // Clear after the last cell, else keep accumulating
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly    <= '0;
            r_vdly   <= '0;
            r_prompt <= 1'b0;
            r_early  <= 1'b0;
            r_deep   <= 1'b0;
        end else if (i_go) begin
            if (i_info.last) begin
                r_dly    <= '0;
                r_vdly   <= '0;
                r_prompt <= 1'b0;
                r_early  <= 1'b0;
                r_deep   <= 1'b0;
            end else begin
                r_dly    <= n_dly;
                r_vdly   <= n_vdly;
                r_prompt <= n_prompt;
                r_early  <= n_early;
                r_deep   <= n_deep;
            end
        end
    end

endmodule

/* hw/rtl/calorimeter_tower_timing_depth_flags_top.sv */
// Channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------------------
// in       | i_in_valid / o_in_ready   | i_mode i_tower_eta i_depth_index i_cell_time
//          |                           | i_cell_energy i_last_cell i_threshold_value
// out      | o_out_valid / i_out_ready | o_tower_flags
// cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
// One item per cycle sustained. A cell reads the threshold table in the cycle it is
// accepted and is classified the next cycle; its flag word (last cell only) is loaded
// into the output register as the cell leaves classify. A table write commits at acceptance.
// Reset loads the register defaults and clears the tower counters; the threshold
// table is not cleared and must be written before cells use it.
// Stall: only a last cell waiting on a full output register holds the classify stage.
module calorimeter_tower_timing_depth_flags_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic signed [5:0]   i_tower_eta,
    input  logic [2:0]          i_depth_index,
    input  logic [5:0]          i_cell_time,
    input  logic [15:0]         i_cell_energy,
    input  logic                i_last_cell,
    input  logic [6:0]          i_threshold_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [5:0]          o_tower_flags,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import ctdf_pkg::*;

    t_cfg              r_cfg;
    logic              cfg_wr;

    logic [ADDR_W-1:0] dec_addr;
    logic              dec_slot_ok;
    t_cell_info        dec_info;

    logic              in_acc;
    logic              ram_we;
    logic              ram_re;
    logic [THR_W-1:0]  ram_rdata;

    logic              r_s1_valid;
    t_cell_info        r_s1_info;
    logic [5:0]        r_s1_time;
    logic [15:0]       r_s1_energy;
    logic              s1_go;

    logic [5:0]        flags;
    logic              r_out_valid;
    logic [5:0]        r_out_flags;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_e_low  <= MIN_E_LOW_RST;
            r_cfg.min_e_high <= MIN_E_HIGH_RST;
            r_cfg.deep_low   <= DEEP_LOW_RST;
            r_cfg.early_low  <= EARLY_LOW_RST;
            r_cfg.deep_high  <= DEEP_HIGH_RST;
            r_cfg.early_high <= EARLY_HIGH_RST;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_E_LOW:  r_cfg.min_e_low  <= i_cfg_data;
                CFG_MIN_E_HIGH: r_cfg.min_e_high <= i_cfg_data;
                CFG_DEEP_LOW:   r_cfg.deep_low   <= i_cfg_data;
                CFG_EARLY_LOW:  r_cfg.early_low  <= i_cfg_data;
                CFG_DEEP_HIGH:  r_cfg.deep_high  <= i_cfg_data;
                CFG_EARLY_HIGH: r_cfg.early_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: decode and table access
    ctdf_decode u_decode (
        .i_tower_eta   (i_tower_eta),
        .i_depth_index (i_depth_index),
        .i_last_cell   (i_last_cell),
        .o_addr        (dec_addr),
        .o_slot_ok     (dec_slot_ok),
        .o_info        (dec_info)
    );

    assign in_acc = i_in_valid && o_in_ready;
    assign ram_we = in_acc && (i_mode == MODE_TABLE) && dec_slot_ok;
    assign ram_re = in_acc && (i_mode == MODE_CELL);

    ctdf_ram #(
        .WIDTH (THR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (dec_addr),
        .i_wdata (i_threshold_value),
        .i_re    (ram_re),
        .i_raddr (dec_addr),
        .o_rdata (ram_rdata)
    );

    // Stage 1 holds one cell; it moves unless its result has nowhere to go
    assign s1_go      = r_s1_valid && (!r_s1_info.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (ram_re) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_info   <= dec_info;
            r_s1_time   <= i_cell_time;
            r_s1_energy <= i_cell_energy;
        end
    end

    // Stage 1: classify and accumulate
    ctdf_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (s1_go),
        .i_info        (r_s1_info),
        .i_cell_time   (r_s1_time),
        .i_cell_energy (r_s1_energy),
        .i_thr         (ram_rdata),
        .i_cfg         (r_cfg),
        .o_flags       (flags)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_info.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_info.last) begin
            r_out_flags <= flags;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tower_flags = r_out_flags;

`ifndef NO_ASSERTIONS
    // A last cell never overruns a flag word that is still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_info.last && r_out_valid && !i_out_ready) |-> !s1_go)
        else $error("classify stage advanced into a held output");

    // Finishing a tower always yields a result in the next cycle
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_info.last) |=> o_out_valid)
        else $error("last cell produced no result");

    // An accepted cell reaches the classify stage
    a_cell_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_s1_valid)
        else $error("accepted cell lost before classify");

    // The table port is used for one access per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("table read and write in the same cycle");
`endif

endmodule
